/* hw/rtl/ssab_pkg.sv */
// Shared types and constants for the supersample alpha blend unit.
// Depends on nothing; imported by every module of the block.

package ssab_pkg;

   // Width of one color or alpha channel.
   localparam int CHAN_W = 8;

   // Number of supersamples per pixel.
   localparam int NUM_SAMPLES = 4;

   // Widths of the configuration port.
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   // Full-scale channel value.
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // ARGB8888 pixel.
   typedef logic [31:0] pixel_type;

   // RGB888 color.
   typedef logic [23:0] rgb_type;

   // Configuration register indexes; other index values select no register.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TINT_MODE  = 2'd0,
      CSR_TINT_COLOR = 2'd1
   } csr_index_type;

   // Tint configuration handed to the compositing logic.
   typedef struct packed {
      logic    mode;
      rgb_type color;
   } tint_cfg_type;

endpackage

/* hw/rtl/ssab_average.sv */
// Masked box average of four ARGB8888 supersamples, per channel, truncating.
// Depends on ssab_pkg.

module ssab_average
   import ssab_pkg::*;
(
   input  pixel_type                    samples [NUM_SAMPLES],
   input  logic      [NUM_SAMPLES-1:0]  sample_valid,
   output pixel_type                    avg_pixel
);

   // Masked copies of the samples: an invalid sample reads as all zero.
   pixel_type masked [NUM_SAMPLES];

   always_comb begin
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         masked[i] = sample_valid[i] ? samples[i] : '0;
      end
   end

   // Each of the four channels is summed independently and divided by four.
   always_comb begin
      logic [CHAN_W+1:0] sum;
      avg_pixel = '0;
      for (int c = 0; c < 4; c++) begin
         sum = {2'b00, masked[0][c*CHAN_W +: CHAN_W]}
             + {2'b00, masked[1][c*CHAN_W +: CHAN_W]}
             + {2'b00, masked[2][c*CHAN_W +: CHAN_W]}
             + {2'b00, masked[3][c*CHAN_W +: CHAN_W]};
         avg_pixel[c*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
      end
   end

endmodule

/* hw/rtl/ssab_composite.sv */
// Tint substitution and source-over compositing of one pixel onto the destination.
// Depends on ssab_pkg.

module ssab_composite
   import ssab_pkg::*;
(
   input  pixel_type    avg_pixel,
   input  pixel_type    dest_pixel,
   input  tint_cfg_type tint_cfg,
   output pixel_type    blended_pixel
);

   // Exact floor(x / 255) for x up to 255 * 255, using the shift-and-add form.
   function automatic logic [CHAN_W-1:0] div_by_255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   pixel_type         src;
   logic [CHAN_W-1:0] alpha;
   logic [CHAN_W-1:0] inv_alpha;

   // In tint mode the averaged alpha is kept and the RGB is replaced.
   always_comb begin
      src = tint_cfg.mode ? {avg_pixel[31:24], tint_cfg.color} : avg_pixel;
      alpha = src[31:24];
      inv_alpha = CHAN_MAX - alpha;
   end

   // Blend each color channel; the output alpha is always full scale.
   always_comb begin
      logic [15:0] weighted;
      blended_pixel = {CHAN_MAX, 24'd0};
      for (int c = 0; c < 3; c++) begin
         weighted = {8'd0, alpha} * {8'd0, src[c*CHAN_W +: CHAN_W]}
                  + {8'd0, inv_alpha} * {8'd0, dest_pixel[c*CHAN_W +: CHAN_W]};
         blended_pixel[c*CHAN_W +: CHAN_W] = div_by_255(weighted);
      end
   end

endmodule

/* hw/rtl/supersample_alpha_blend_unit.sv */
// Supersample alpha blend unit: an accepted input transaction passes through the input
// register, then the result register, to its result on the rsp_ channel. Throughput
// is one pixel per clock unless rsp_tready stalls the result channel; the blend logic
// between the two registers is a single pass with no iteration. Reset is synchronous
// and active high: it clears both valid flags and sets tint_mode and tint_color to zero.
// Depends on ssab_pkg, ssab_average and ssab_composite.

module supersample_alpha_blend_unit
   import ssab_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // Input channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: sample_zero[31:0], sample_one[63:32], sample_two[95:64],
   //        sample_three[127:96], dest_pixel[159:128]
   input  logic [159:0]           req_tdata,
   // tuser: sample_valid[3:0]
   input  logic [3:0]             req_tuser,

   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: blended_pixel[31:0]
   output logic [31:0]            rsp_tdata,

   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic    tint_mode_ff, tint_mode_in;
   rgb_type tint_color_ff, tint_color_in;

   // Input stage registers.
   logic                   in_valid_ff, in_valid_in;
   pixel_type              samples_ff [NUM_SAMPLES];
   logic [NUM_SAMPLES-1:0] sample_valid_ff;
   pixel_type              dest_ff;

   // Result stage registers.
   logic      out_valid_ff, out_valid_in;
   pixel_type out_pixel_ff;

   logic         out_load;
   logic         in_load;
   pixel_type    avg_pixel;
   pixel_type    blended_pixel;
   tint_cfg_type tint_cfg;

   // Register writes keep only the low bits of the written value.
   always_comb begin
      tint_mode_in = tint_mode_ff;
      tint_color_in = tint_color_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TINT_MODE:  tint_mode_in = csr_wdata[0];
            CSR_TINT_COLOR: tint_color_in = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_mode_ff <= 1'b0;
         tint_color_ff <= '0;
      end else begin
         tint_mode_ff <= tint_mode_in;
         tint_color_ff <= tint_color_in;
      end
   end

   // Pipeline flow control: the result register loads when empty or being drained.
   always_comb begin
      out_load = !out_valid_ff || rsp_tready;
      in_load = !in_valid_ff || out_load;
      req_tready = in_load;
      in_valid_in = in_load ? req_tvalid : in_valid_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   // Input stage: capture the transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         for (int i = 0; i < NUM_SAMPLES; i++) begin
            samples_ff[i] <= req_tdata[i*32 +: 32];
         end
         sample_valid_ff <= req_tuser;
         dest_ff <= req_tdata[159:128];
      end
   end

   // Blend datapath.
   assign tint_cfg = '{mode: tint_mode_ff, color: tint_color_ff};

   ssab_average u_average (
      .samples      (samples_ff),
      .sample_valid (sample_valid_ff),
      .avg_pixel    (avg_pixel)
   );

   ssab_composite u_composite (
      .avg_pixel     (avg_pixel),
      .dest_pixel    (dest_ff),
      .tint_cfg      (tint_cfg),
      .blended_pixel (blended_pixel)
   );

   // Result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         out_pixel_ff <= blended_pixel;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_pixel_ff;

   // The result channel is empty right after reset.
   assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("result valid set after reset");

   // A delivered pixel always carries full alpha.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_pixel_ff[31:24] == CHAN_MAX))
      else $error("result alpha is not full scale");

   // With both stages full and the output stalled, no new transaction is taken.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline is full");

   // An accepted transaction occupies the input stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted transaction lost in input stage");

   // A pending input item moves into the result register when it is free.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (!out_valid_ff || rsp_tready)) |=> out_valid_ff)
      else $error("input stage item not forwarded to result register");

endmodule

/* test/tb_supersample_alpha_blend_unit.sv */
// Self-checking regression for the supersample alpha blend unit: directed and random
// pixel traffic with stalls on both channels, checked against a cycle-free predictor.
// Depends on ssab_pkg and the supersample_alpha_blend_unit RTL.
`timescale 1ns / 1ps

module tb_supersample_alpha_blend_unit;
   import ssab_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   // Stall patterns of the result-side receiver.
   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC
   } rx_pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // tdata: sample_zero, sample_one, sample_two, sample_three, dest_pixel (low bit up)
   logic [159:0]          req_tdata;
   // tuser: sample_valid
   logic [3:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tdata: blended_pixel
   logic [31:0]           rsp_tdata;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the tint registers used by the predictor.
   logic                  shadow_tint_mode;
   rgb_type               shadow_tint_color;

   // Blended pixels still owed by the block, oldest first.
   pixel_type             blend_expect_q[$];

   rx_pattern_type        rx_pattern;
   int                    hold_off_left;
   int                    failure_count;
   int                    cycle_count;

   supersample_alpha_blend_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Box-average the valid samples, apply the tint, then composite over the destination.
   function automatic pixel_type blend_predict(input logic [127:0] samples,
                                               input logic [3:0] valid,
                                               input pixel_type dest);
      pixel_type   src;
      pixel_type   blended;
      logic [9:0]  sum;
      logic [15:0] weighted;
      logic [7:0]  alpha;
      src = '0;
      for (int ch = 0; ch < 4; ch++) begin
         sum = '0;
         for (int k = 0; k < NUM_SAMPLES; k++) begin
            if (valid[k]) sum = sum + 10'(samples[32*k + 8*ch +: 8]);
         end
         src[8*ch +: 8] = sum[9:2];
      end
      if (shadow_tint_mode) src[23:0] = shadow_tint_color;
      alpha = src[31:24];
      blended = {CHAN_MAX, 24'h0};
      for (int ch = 0; ch < 3; ch++) begin
         weighted = 16'(alpha) * 16'(src[8*ch +: 8])
                  + 16'(8'(CHAN_MAX - alpha)) * 16'(dest[8*ch +: 8]);
         blended[8*ch +: 8] = 8'(weighted / 16'd255);
      end
      return blended;
   endfunction

   // A sample biased toward opaque, transparent and saturated values.
   function automatic pixel_type random_sample();
      case ($urandom_range(0, 5))
         0: return {CHAN_MAX, 24'($urandom)};
         1: return {8'h00, 24'($urandom)};
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return 32'($urandom);
      endcase
   endfunction

   // Offer one transaction and hold it until the block accepts it.
   task automatic send_pixel(input logic [127:0] samples, input logic [3:0] valid,
                             input pixel_type dest);
      @(negedge clock);
      req_tdata = {dest, samples};
      req_tuser = valid;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_pixel();
      logic [127:0] samples;
      logic [3:0]   valid;
      samples = {random_sample(), random_sample(), random_sample(), random_sample()};
      valid = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
      send_pixel(samples, valid, ($urandom_range(0, 7) == 0) ? random_sample()
                                                             : 32'($urandom));
   endtask

   // Leave the input channel idle for a number of cycles.
   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every owed pixel has come back.
   task automatic wait_for_results();
      sender_gap(1);
      while (blend_expect_q.size() != 0) @(negedge clock);
   endtask

   // Registers change only while nothing is in flight.
   task automatic write_register(input csr_index_type index, input logic [23:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == CSR_TINT_MODE) shadow_tint_mode = value[0];
      else shadow_tint_color = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_receiver(input rx_pattern_type pattern);
      @(posedge clock);
      rx_pattern = pattern;
   endtask

   // Corner pixels with the reset tint settings: masks, saturation and transparency.
   task automatic test_directed_blend();
      set_receiver(RX_ALWAYS);
      send_pixel('0, 4'h0, 32'h0000_0000);
      send_pixel('0, 4'h0, 32'hFFFF_FFFF);
      // All samples invalid: only the destination color survives.
      send_pixel({4{32'hFFFF_FFFF}}, 4'h0, 32'h1234_5678);
      send_pixel({4{32'hFFFF_FFFF}}, 4'hF, 32'h0000_0000);
      // Full alpha: the averaged source replaces the destination.
      send_pixel({4{32'hFFFF_FFFF}}, 4'hF, 32'h89AB_CDEF);
      send_pixel({{CHAN_MAX, 24'h102030}, {CHAN_MAX, 24'h405060},
                  {CHAN_MAX, 24'h708090}, {CHAN_MAX, 24'hA0B0C0}}, 4'hF, 32'($urandom));
      // One valid sample at a time.
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         send_pixel({4{32'hFFFF_FFFF}}, 4'(1 << k), 32'h0000_0000);
      end
      send_pixel({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 4'hF,
                 32'h5A5A_5A5A);
      send_pixel({32'h00FF_FFFF, 32'h0012_3456, 32'h00AB_CDEF, 32'h0000_0000}, 4'hF,
                 32'hFFC3_3C96);
      send_pixel({random_sample(), random_sample(), random_sample(), random_sample()},
                 4'b0101, 32'($urandom));
      wait_for_results();
   endtask

   // Tint mode with the extreme colors, opaque and transparent sources.
   task automatic test_directed_tint();
      write_register(CSR_TINT_MODE, 24'h00_0001);
      write_register(CSR_TINT_COLOR, 24'hFF_FFFF);
      send_pixel({4{32'hFFFF_FFFF}}, 4'hF, 32'h0000_0000);
      send_pixel({4{32'hFFFF_FFFF}}, 4'h0, 32'h7F80_81FE);
      send_pixel({random_sample(), random_sample(), random_sample(), random_sample()},
                 4'hF, 32'($urandom));
      wait_for_results();
      write_register(CSR_TINT_COLOR, 24'h00_0000);
      send_pixel({4{32'hFF12_3456}}, 4'hF, 32'hFFFF_FFFF);
      send_pixel({4{32'h8012_3456}}, 4'hF, 32'hFFFF_FFFF);
      wait_for_results();
      write_register(CSR_TINT_COLOR, 24'($urandom));
      send_pixel({4{32'h80FF_FFFF}}, 4'b1010, 32'($urandom));
      wait_for_results();
   endtask

   // Only bit 0 of a write to the mode register takes effect.
   task automatic test_register_masking();
      write_register(CSR_TINT_COLOR, 24'hC0_FFEE);
      write_register(CSR_TINT_MODE, 24'hFF_FFFE);
      send_pixel({4{32'hFF01_0203}}, 4'hF, 32'($urandom));
      wait_for_results();
      write_register(CSR_TINT_MODE, 24'h80_0001);
      send_pixel({4{32'hFF01_0203}}, 4'hF, 32'($urandom));
      wait_for_results();
   endtask

   // Receiver holds off while the sender keeps offering, so the input side must stall.
   task automatic test_backpressure();
      set_receiver(RX_ALWAYS);
      @(posedge clock);
      hold_off_left = 80;
      repeat (60) send_random_pixel();
      wait_for_results();
   endtask

   // Random bursts under one tint setting and one receiver pattern.
   task automatic test_random_traffic(input logic mode, input rgb_type color,
                                      input rx_pattern_type pattern, input int count,
                                      input int max_gap);
      int sent;
      int burst;
      write_register(CSR_TINT_MODE, {23'($urandom), mode});
      write_register(CSR_TINT_COLOR, color);
      set_receiver(pattern);
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_random_pixel();
            sent++;
         end
         if (max_gap > 0) sender_gap($urandom_range(0, max_gap));
      end
      wait_for_results();
   endtask

   // Receiver: a long hold-off when requested, otherwise the current stall pattern.
   initial begin
      int rx_tick;
      rx_tick = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rx_tick++;
         if (hold_off_left > 0) begin
            rsp_tready = 1'b0;
            hold_off_left--;
         end else begin
            case (rx_pattern)
               RX_ALWAYS:   rsp_tready = 1'b1;
               RX_RANDOM:   rsp_tready = ($urandom_range(0, 99) < 60);
               RX_PERIODIC: rsp_tready = ((rx_tick % 7) < 4);
               default:     rsp_tready = 1'b1;
            endcase
         end
      end
   end

   // Record the prediction for each accepted input, then check each accepted result.
   always @(posedge clock) begin
      pixel_type expected;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            blend_expect_q.push_back(blend_predict(req_tdata[127:0], req_tuser,
                                                   req_tdata[159:128]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (blend_expect_q.size() == 0) begin
               if (failure_count < REPORT_LIMIT) begin
                  $display("unexpected blended pixel %h with nothing pending", rsp_tdata);
               end
               failure_count++;
            end else begin
               expected = blend_expect_q.pop_front();
               if (rsp_tdata !== expected) begin
                  if (failure_count < REPORT_LIMIT) begin
                     $display("blended_pixel mismatch: expected %h, actual %h",
                              expected, rsp_tdata);
                  end
                  failure_count++;
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("supersample_alpha_blend_unit regression: fail");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = CSR_TINT_MODE;
      csr_wdata = '0;
      shadow_tint_mode = 1'b0;
      shadow_tint_color = '0;
      rx_pattern = RX_ALWAYS;
      hold_off_left = 0;
      failure_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_blend();
      test_directed_tint();
      test_register_masking();
      test_backpressure();
      test_random_traffic(1'b0, 24'($urandom), RX_ALWAYS, 150, 0);
      test_random_traffic(1'b0, 24'($urandom), RX_RANDOM, 450, 5);
      test_random_traffic(1'b1, 24'h00_0000, RX_PERIODIC, 250, 3);
      test_random_traffic(1'b1, 24'hFF_FFFF, RX_RANDOM, 250, 4);
      test_random_traffic(1'b1, 24'($urandom), RX_RANDOM, 400, 6);
      test_random_traffic(1'b0, 24'($urandom), RX_PERIODIC, 350, 2);

      // Let the pipeline settle so any stray result is caught.
      repeat (10) @(posedge clock);
      if (failure_count == 0 && blend_expect_q.size() == 0) begin
         $display("supersample_alpha_blend_unit regression: pass");
      end else begin
         $display("supersample_alpha_blend_unit regression: fail");
      end
      $finish;
   end

endmodule
